// ----- rtl/core/tvc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_pkg: shared types and constants of the triangle view cull block
// register map, configuration bundle and fixed field widths
// ----------------------------------------------------------------------------
package tvc_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int MAX_EYES_DEF    = 4;

   localparam int EYE_REGS    = 4;
   localparam int EYE_W       = 16;
   localparam int EYE_VEC_W   = 3 * EYE_W;
   localparam int EYE_COUNT_W = 3;
   localparam int MASK_W      = 4;

   // partial product slice width of the split multipliers
   localparam int LIMB_W = 32;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_IDX_LO = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_EYE_COUNT = 3'd0,
      REG_EYE0      = 3'd1,
      REG_EYE1      = 3'd2,
      REG_EYE2      = 3'd3,
      REG_EYE3      = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [EYE_COUNT_W-1:0]               eye_count;
      logic [EYE_REGS-1:0][EYE_VEC_W-1:0]   eye_vec;
   } tvc_cfg_type;

endpackage
`default_nettype wire

// ----- rtl/core/tvc_ifs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_ifs: triangle and result channels
// valid/ready channels carrying one triangle or one cull decision per transfer
// ----------------------------------------------------------------------------
interface tvc_req_if #(
   parameter int CW = tvc_pkg::COORD_WIDTH_DEF
);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] a_x;
   logic signed [CW-1:0] a_y;
   logic signed [CW-1:0] a_z;
   logic signed [CW-1:0] b_x;
   logic signed [CW-1:0] b_y;
   logic signed [CW-1:0] b_z;
   logic signed [CW-1:0] c_x;
   logic signed [CW-1:0] c_y;
   logic signed [CW-1:0] c_z;

   modport source (
      output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
      input  ready
   );
   modport sink (
      input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
      output ready
   );
endinterface

interface tvc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      keep;
   logic [tvc_pkg::MASK_W-1:0] facing_mask;

   modport source (
      output valid, keep, facing_mask,
      input  ready
   );
   modport sink (
      input  valid, keep, facing_mask,
      output ready
   );
endinterface
`default_nettype wire

// ----- rtl/core/triangle_view_cull.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_view_cull: multi-view back-face culling
// decides per triangle whether it faces away from every configured eye
// ----------------------------------------------------------------------------
// One triangle is taken per clock cycle and one result leaves per cycle once
// the pipe is full and while the result side is ready; the sustained rate is
// one transfer each cycle, set by the fully pipelined per-eye lanes of the
// back end, each with its own split multipliers. Between an input transfer
// and its result lie the edge vector and cross product registers of the
// intake, the four-entry normal queue and the eye test pipe. The intake and
// the eye tests stall on their own, so a stalled result side still lets the
// intake run until the queue fills: up to fourteen triangles can be in
// flight, eight in the eye test pipe, four queued and two in the intake.
// A triangle
// is culled (keep low) only when every eye in use sees its normal N within
// the cone dot(N,e) > 0.1*|N|*|e|, evaluated exactly as d > 0 and
// 100*d^2 > |N|^2*|e|^2; with no eyes in use every triangle is culled.
// Registers sit at byte offsets 8*i on a 64-bit port and must be written
// only while no triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_view_cull #(
   parameter int COORD_WIDTH = tvc_pkg::COORD_WIDTH_DEF,
   parameter int MAX_EYES    = tvc_pkg::MAX_EYES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   tvc_req_if.sink                            req_chan,
   tvc_rsp_if.source                          rsp_chan,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tvc_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tvc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tvc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);
   import tvc_pkg::*;

   localparam int NW = 2 * (COORD_WIDTH + 1) + 1;
   localparam int QW = 3 * NW;

   // configuration registers
   logic [EYE_COUNT_W-1:0]             eye_count_ff, eye_count_in;
   logic [EYE_REGS-1:0][EYE_VEC_W-1:0] eye_vec_ff, eye_vec_in;
   logic                               csr_wr;
   csr_reg_type                        csr_idx;
   tvc_cfg_type                        cfg;

   // intake to queue, queue to eye tests
   logic          q_push, q_push_ready;
   logic [QW-1:0] q_push_data;
   logic          q_pop, q_pop_valid;
   logic [QW-1:0] q_pop_data;

   // ---------------------------------------------------------------------
   // register port: writes land in the access cycle, pready tied high
   // ---------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_reg_type'(paddr[CSR_IDX_LO +: CSR_IDX_W]);

   always_comb begin
      eye_count_in = eye_count_ff;
      eye_vec_in   = eye_vec_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_EYE_COUNT: eye_count_in  = pwdata[EYE_COUNT_W-1:0];
            REG_EYE0:      eye_vec_in[0] = pwdata[EYE_VEC_W-1:0];
            REG_EYE1:      eye_vec_in[1] = pwdata[EYE_VEC_W-1:0];
            REG_EYE2:      eye_vec_in[2] = pwdata[EYE_VEC_W-1:0];
            REG_EYE3:      eye_vec_in[3] = pwdata[EYE_VEC_W-1:0];
            default: begin
               // offsets past the register list are dropped
               eye_count_in = eye_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_count_ff <= '0;
         eye_vec_ff   <= '0;
      end else begin
         eye_count_ff <= eye_count_in;
         eye_vec_ff   <= eye_vec_in;
      end
   end

   // read back
   always_comb begin
      case (csr_idx)
         REG_EYE_COUNT: prdata = CSR_DATA_W'(eye_count_ff);
         REG_EYE0:      prdata = CSR_DATA_W'(eye_vec_ff[0]);
         REG_EYE1:      prdata = CSR_DATA_W'(eye_vec_ff[1]);
         REG_EYE2:      prdata = CSR_DATA_W'(eye_vec_ff[2]);
         REG_EYE3:      prdata = CSR_DATA_W'(eye_vec_ff[3]);
         default:       prdata = '0;
      endcase
   end

   assign cfg.eye_count = eye_count_ff;
   assign cfg.eye_vec   = eye_vec_ff;

   // ---------------------------------------------------------------------
   // intake: edge vectors and face normal
   // ---------------------------------------------------------------------
   tvc_front #(.CW(COORD_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_push   (q_push),
      .q_data   (q_push_data),
      .q_ready  (q_push_ready)
   );

   // ---------------------------------------------------------------------
   // normal queue decouples intake stalls from result stalls
   // ---------------------------------------------------------------------
   tvc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_pop_valid),
      .pop_data   (q_pop_data)
   );

   // ---------------------------------------------------------------------
   // eye tests and keep decision, result register at the end
   // ---------------------------------------------------------------------
   tvc_back #(.CW(COORD_WIDTH), .MAX_EYES(MAX_EYES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_pop_valid),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire

// ----- rtl/core/tvc_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_mul: pipelined unsigned multiplier
// operands cut into limb slices, partial products registered, then summed
// into a registered product
module tvc_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [AW-1:0] a,
   input  wire logic [BW-1:0] b,
   output logic [AW+BW-1:0]   p
);
   import tvc_pkg::*;

   localparam int NA  = (AW + LIMB_W - 1) / LIMB_W;
   localparam int NB  = (BW + LIMB_W - 1) / LIMB_W;
   localparam int APW = NA * LIMB_W;
   localparam int BPW = NB * LIMB_W;
   localparam int PW  = AW + BW;

   logic [APW-1:0]        a_pad;
   logic [BPW-1:0]        b_pad;
   logic [2*LIMB_W-1:0]   pp_ff [NA][NB];
   logic [PW-1:0]         p_in;
   logic [PW-1:0]         p_ff;

   assign a_pad = APW'(a);
   assign b_pad = BPW'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= (2*LIMB_W)'(a_pad[i*LIMB_W +: LIMB_W])
                            * (2*LIMB_W)'(b_pad[j*LIMB_W +: LIMB_W]);
            end
         end
      end
   end

   always_comb begin
      p_in = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            p_in = p_in + (PW'(pp_ff[i][j]) << (LIMB_W * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// ----- rtl/core/tvc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_front: triangle intake and face normal
// edge vectors, then cross product, pushed into the normal queue
// ----------------------------------------------------------------------------
module tvc_front #(
   parameter int CW = tvc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   tvc_req_if.sink                req_chan,
   output logic                   q_push,
   output logic [3*(2*CW+3)-1:0]  q_data,
   input  wire logic              q_ready
);
   localparam int DW = CW + 1;
   localparam int NW = 2 * DW + 1;

   logic                 f1_v_ff, f1_v_in;
   logic                 f2_v_ff, f2_v_in;
   logic                 adv1, adv2;
   logic signed [DW-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   logic signed [2*DW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
   logic signed [NW-1:0] nx_ff, ny_ff, nz_ff;

   assign adv2 = !f2_v_ff || q_ready;
   assign adv1 = !f1_v_ff || adv2;
   assign req_chan.ready = adv1;

   assign f1_v_in = adv1 ? req_chan.valid : f1_v_ff;
   assign f2_v_in = adv2 ? f1_v_ff : f2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         f1_v_ff <= f1_v_in;
         f2_v_ff <= f2_v_in;
      end
   end

   // edge vectors b-a and c-a
   always_ff @(posedge clock) begin
      if (adv1) begin
         ux_ff <= DW'(req_chan.b_x) - DW'(req_chan.a_x);
         uy_ff <= DW'(req_chan.b_y) - DW'(req_chan.a_y);
         uz_ff <= DW'(req_chan.b_z) - DW'(req_chan.a_z);
         vx_ff <= DW'(req_chan.c_x) - DW'(req_chan.a_x);
         vy_ff <= DW'(req_chan.c_y) - DW'(req_chan.a_y);
         vz_ff <= DW'(req_chan.c_z) - DW'(req_chan.a_z);
      end
   end

   assign p_yz = uy_ff * vz_ff;
   assign p_zy = uz_ff * vy_ff;
   assign p_zx = uz_ff * vx_ff;
   assign p_xz = ux_ff * vz_ff;
   assign p_xy = ux_ff * vy_ff;
   assign p_yx = uy_ff * vx_ff;

   always_ff @(posedge clock) begin
      if (adv2) begin
         nx_ff <= NW'(p_yz) - NW'(p_zy);
         ny_ff <= NW'(p_zx) - NW'(p_xz);
         nz_ff <= NW'(p_xy) - NW'(p_yx);
      end
   end

   assign q_push = f2_v_ff && q_ready;
   assign q_data = {nz_ff, ny_ff, nx_ff};

endmodule
`default_nettype wire

// ----- rtl/core/tvc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_queue: normal queue
// small first-in first-out buffer between intake and eye tests
// ----------------------------------------------------------------------------
module tvc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tvc_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  push_ready,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data
);
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   assign push_ready = cnt_ff != CNTW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/tvc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_back: per-eye facing test
// eight-stage pipeline from the normal to the keep decision, one lane per eye
// ----------------------------------------------------------------------------
module tvc_back #(
   parameter int CW       = tvc_pkg::COORD_WIDTH_DEF,
   parameter int MAX_EYES = tvc_pkg::MAX_EYES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tvc_pkg::tvc_cfg_type cfg,
   input  wire logic                q_valid,
   input  wire logic [3*(2*CW+3)-1:0] q_data,
   output logic                     q_pop,
   tvc_rsp_if.source                rsp_chan
);
   import tvc_pkg::*;

   localparam int DW     = CW + 1;
   localparam int NW     = 2 * DW + 1;
   localparam int NMW    = NW - 1;
   localparam int SQW    = 2 * NMW;
   localparam int NNW    = SQW + 2;
   localparam int PRW    = NW + EYE_W;
   localparam int DTW    = PRW + 2;
   localparam int DMW    = DTW - 1;
   localparam int DSQW   = 2 * DMW;
   localparam int LHSW   = DSQW + 7;
   localparam int ESQW   = 2 * EYE_W;
   localparam int RHSW   = NNW + ESQW;
   localparam int CMPW   = (LHSW > RHSW) ? LHSW : RHSW;
   localparam int NLANE  = (MAX_EYES < EYE_REGS) ? MAX_EYES : EYE_REGS;
   localparam int NSTAGE = 8;

   logic [NSTAGE-1:0] v_ff, v_in;
   logic              adv;

   logic signed [NW-1:0]    n_ff   [3];
   logic [NMW-1:0]          nmag   [3];
   logic [SQW-1:0]          sq     [3];
   logic [NNW-1:0]          nn_ff;

   logic signed [EYE_W-1:0] eye    [NLANE][3];
   logic signed [PRW-1:0]   prod_ff [NLANE][3];
   logic [ESQW-1:0]         esqc_ff [NLANE][3];
   logic signed [DTW-1:0]   d_ff   [NLANE];
   logic [ESQW-1:0]         esq3_ff [NLANE];
   logic [ESQW-1:0]         esq4_ff [NLANE];
   logic [DMW-1:0]          dmag   [NLANE];
   logic [DSQW-1:0]         dsq    [NLANE];
   logic [DSQW-1:0]         dsq6_ff [NLANE];
   logic [RHSW-1:0]         rhs    [NLANE];
   logic [LHSW-1:0]         lhs7_ff [NLANE];
   logic [RHSW-1:0]         rhs7_ff [NLANE];
   logic [NLANE-1:0]        pos4_ff, pos5_ff, pos6_ff, pos7_ff;

   logic [EYE_COUNT_W-1:0]  cnt;
   logic [MASK_W-1:0]       pass;
   logic [MASK_W:0]         full;
   logic                    keep_ff, keep_in;
   logic [MASK_W-1:0]       mask_ff;

   // whole pipeline moves together; the last stage is the result register
   assign adv   = !v_ff[NSTAGE-1] || rsp_chan.ready;
   assign q_pop = adv && q_valid;
   assign v_in  = adv ? {v_ff[NSTAGE-2:0], q_valid} : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1: normal out of the queue
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            n_ff[k] <= q_data[k*NW +: NW];
         end
      end
   end

   // squared normal components, stages 2 and 3
   for (genvar k = 0; k < 3; k++) begin : g_nsq
      assign nmag[k] = n_ff[k][NW-1] ? NMW'(-n_ff[k]) : NMW'(n_ff[k]);
      tvc_mul #(.AW(NMW), .BW(NMW)) u_nsq (
         .clock (clock),
         .en    (adv),
         .a     (nmag[k]),
         .b     (nmag[k]),
         .p     (sq[k])
      );
   end

   // stage 4: squared length of the normal
   always_ff @(posedge clock) begin
      if (adv) begin
         nn_ff <= NNW'(sq[0]) + NNW'(sq[1]) + NNW'(sq[2]);
      end
   end

   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      for (genvar k = 0; k < 3; k++) begin : g_comp
         assign eye[l][k] = cfg.eye_vec[l][k*EYE_W +: EYE_W];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            // stage 2: products per component
            for (int k = 0; k < 3; k++) begin
               prod_ff[l][k] <= n_ff[k] * eye[l][k];
               esqc_ff[l][k] <= $unsigned(ESQW'(eye[l][k] * eye[l][k]));
            end
            // stage 3: dot product and squared eye length
            d_ff[l]    <= DTW'(prod_ff[l][0]) + DTW'(prod_ff[l][1]) + DTW'(prod_ff[l][2]);
            esq3_ff[l] <= esqc_ff[l][0] + esqc_ff[l][1] + esqc_ff[l][2];
            // stage 4
            pos4_ff[l] <= !d_ff[l][DTW-1] && (d_ff[l] != '0);
            esq4_ff[l] <= esq3_ff[l];
            // stages 5 and 6 wait on the multipliers
            pos5_ff[l] <= pos4_ff[l];
            pos6_ff[l] <= pos5_ff[l];
            dsq6_ff[l] <= dsq[l];
            // stage 7: times one hundred as shifts
            pos7_ff[l] <= pos6_ff[l];
            lhs7_ff[l] <= (LHSW'(dsq6_ff[l]) << 6) + (LHSW'(dsq6_ff[l]) << 5)
                        + (LHSW'(dsq6_ff[l]) << 2);
            rhs7_ff[l] <= rhs[l];
         end
      end

      // only a positive dot product is squared
      assign dmag[l] = d_ff[l][DTW-1] ? '0 : d_ff[l][DMW-1:0];

      tvc_mul #(.AW(DMW), .BW(DMW)) u_dsq (
         .clock (clock),
         .en    (adv),
         .a     (dmag[l]),
         .b     (dmag[l]),
         .p     (dsq[l])
      );

      tvc_mul #(.AW(NNW), .BW(ESQW)) u_rhs (
         .clock (clock),
         .en    (adv),
         .a     (nn_ff),
         .b     (esq4_ff[l]),
         .p     (rhs[l])
      );
   end

   // eyes in use, limited by the lanes built
   assign cnt = (cfg.eye_count > EYE_COUNT_W'(NLANE)) ? EYE_COUNT_W'(NLANE)
                                                      : cfg.eye_count;

   for (genvar l = 0; l < MASK_W; l++) begin : g_pass
      if (l < NLANE) begin : g_used
         assign pass[l] = pos7_ff[l] && (EYE_COUNT_W'(l) < cnt)
                       && (CMPW'(lhs7_ff[l]) > CMPW'(rhs7_ff[l]));
      end else begin : g_unused
         assign pass[l] = 1'b0;
      end
   end

   assign full    = ((MASK_W+1)'(1) << cnt) - 1'b1;
   assign keep_in = (cnt != '0) && ({1'b0, pass} != full);

   // stage 8: result register
   always_ff @(posedge clock) begin
      if (adv) begin
         keep_ff <= keep_in;
         mask_ff <= pass;
      end
   end

   assign rsp_chan.valid       = v_ff[NSTAGE-1];
   assign rsp_chan.keep        = keep_ff;
   assign rsp_chan.facing_mask = mask_ff;

endmodule
`default_nettype wire

// ----- rtl/core/tvc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tvc_checker: port-level checks of the triangle view cull block
// results only for pending transfers, reset, keep decision shape, stall hold, register port
// ----------------------------------------------------------------------------
module tvc_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic                       rsp_keep,
   input wire logic [tvc_pkg::MASK_W-1:0] rsp_mask,
   input wire logic                       pready
);
   import tvc_pkg::*;

   logic [7:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no result left over across reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a result only for a triangle taken earlier
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 8'd0)
      else $error("result without a pending triangle");

   // a culled triangle passed every eye in use: mask is a run of low ones
   a_cull_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_keep |-> ((rsp_mask & (rsp_mask + 4'd1)) == 4'd0))
      else $error("cull decision does not match facing mask");

   // held result stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep) && $stable(rsp_mask))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");

endmodule

bind triangle_view_cull tvc_checker u_tvc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_keep  (rsp_chan.keep),
   .rsp_mask  (rsp_chan.facing_mask),
   .pready    (pready)
);
`default_nettype wire

// ----- dv/triangle_view_cull_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_view_cull_tb: self-checking bench for the triangle view cull block
// a directed table of triangles and register writes, then random triangles
// over many eye setups; each decision is checked against a typed-in value or
// an exact integer model of the cone test, with random gaps on both channels
// ----------------------------------------------------------------------------
module triangle_view_cull_tb;
   import tvc_pkg::*;

   localparam int CW        = COORD_WIDTH_DEF;
   localparam int COORD_MIN = -32768;
   localparam int COORD_MAX = 32767;

   // register index past the end of the map, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd5;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 200;
   // leave some margin past the transfer-to-result latency
   localparam int DRAIN_CYCLES    = 16;

   typedef struct packed {
      logic signed [CW-1:0] a_x, a_y, a_z;
      logic signed [CW-1:0] b_x, b_y, b_z;
      logic signed [CW-1:0] c_x, c_y, c_z;
   } triangle_type;

   typedef struct packed {
      logic              keep;
      logic [MASK_W-1:0] facing_mask;
   } cull_type;

   // directed table rows: a register write, a triangle with a typed-in
   // decision, or a triangle left to the predictor
   typedef enum logic [1:0] {ROW_CSR, ROW_GOLD, ROW_PRED} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_value;
      triangle_type          vtx;
      cull_type              gold;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tvc_req_if #(.CW(CW)) req_bus ();
   tvc_rsp_if            rsp_bus ();

   triangle_view_cull u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // bench copy of the eye registers
   tvc_cfg_type eye_setup = '0;

   // decisions of triangles offered but not yet transferred
   cull_type staged_q [$];
   // decisions of transferred triangles still waiting for their result
   cull_type awaited_q [$];

   plan_row_type plan_q [$];

   int mismatch_count = 0;
   bit idling_on      = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // small helpers
   // --------------------------------------------------------------------------

   // uniform integer in [-m, m]
   function automatic int spread(input int m);
      return int'($urandom_range(0, 2 * m)) - m;
   endfunction

   function automatic int corner_value();
      case ($urandom_range(0, 4))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // most gaps short, a few long; none at all while idling is off
   function automatic int pick_gap();
      int roll;
      if (!idling_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic triangle_type tri_of(input int ax, input int ay, input int az,
                                           input int bx, input int by, input int bz,
                                           input int cx, input int cy, input int cz);
      triangle_type t;
      t.a_x = CW'(ax); t.a_y = CW'(ay); t.a_z = CW'(az);
      t.b_x = CW'(bx); t.b_y = CW'(by); t.b_z = CW'(bz);
      t.c_x = CW'(cx); t.c_y = CW'(cy); t.c_z = CW'(cz);
      return t;
   endfunction

   // x in the low slice, then y, then z
   function automatic logic [CSR_DATA_W-1:0] eye_pack(input int x, input int y, input int z);
      return {16'h0, EYE_W'(z), EYE_W'(y), EYE_W'(x)};
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 200)
         $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // --------------------------------------------------------------------------
   // predictor: exact cone test per eye, 128-bit signed is ample
   // (|N|^2*|e|^2 stays below 2^103, 100*d^2 below 2^113)
   // --------------------------------------------------------------------------
   function automatic cull_type cull_decision(input triangle_type t);
      longint              ux, uy, uz, vx, vy, vz;
      logic signed [127:0] nrm [3];
      logic signed [127:0] eye [3];
      logic signed [127:0] norm_sq, eye_sq, dot;
      int                  in_use, i, k;
      cull_type            r;
      ux = longint'(t.b_x) - longint'(t.a_x);
      uy = longint'(t.b_y) - longint'(t.a_y);
      uz = longint'(t.b_z) - longint'(t.a_z);
      vx = longint'(t.c_x) - longint'(t.a_x);
      vy = longint'(t.c_y) - longint'(t.a_y);
      vz = longint'(t.c_z) - longint'(t.a_z);
      nrm[0] = uy * vz - uz * vy;
      nrm[1] = uz * vx - ux * vz;
      nrm[2] = ux * vy - uy * vx;
      norm_sq = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];

      // oversized counts saturate
      in_use = eye_setup.eye_count;
      if (in_use > MAX_EYES_DEF) in_use = MAX_EYES_DEF;
      if (in_use > EYE_REGS) in_use = EYE_REGS;

      r.facing_mask = '0;
      for (i = 0; i < in_use; i++) begin
         for (k = 0; k < 3; k++)
            eye[k] = $signed(eye_setup.eye_vec[i][k*EYE_W +: EYE_W]);
         dot    = nrm[0] * eye[0] + nrm[1] * eye[1] + nrm[2] * eye[2];
         eye_sq = eye[0] * eye[0] + eye[1] * eye[1] + eye[2] * eye[2];
         if (dot > 0 && dot * dot * 100 > norm_sq * eye_sq)
            r.facing_mask[i] = 1'b1;
      end
      r.keep = (in_use != 0) && (int'(r.facing_mask) != (1 << in_use) - 1);
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // stimulus builders
   // --------------------------------------------------------------------------
   function automatic triangle_type random_triangle(input int axis);
      int pt [9];
      int roll, span, d, j, k;
      roll = $urandom_range(0, 99);
      span = 1 << $urandom_range(1, 14);
      for (k = 0; k < 3; k++) pt[k] = spread(16000);
      // mostly flat triangles whose normal runs along the eye cluster axis
      for (j = 1; j < 3; j++)
         for (k = 0; k < 3; k++)
            pt[3*j+k] = pt[k] + ((k == axis) ? spread(span / 8) : spread(span));
      if (roll >= 55 && roll < 70) begin
         for (k = 0; k < 9; k++) pt[k] = int'($urandom_range(0, 65535)) - 32768;
      end else if (roll >= 70 && roll < 80) begin
         for (k = 3; k < 9; k++) pt[k] = pt[k % 3] + spread(64);
      end else if (roll >= 80 && roll < 90) begin
         // degenerate: collinear points, sometimes a repeated vertex
         for (k = 0; k < 3; k++) begin
            d = spread(4000);
            pt[3+k] = pt[k] + d;
            pt[6+k] = pt[k] + 2 * d;
         end
         if ($urandom_range(0, 2) == 0)
            for (k = 0; k < 3; k++) pt[3+k] = pt[k];
      end else if (roll >= 90) begin
         for (k = 0; k < 9; k++) pt[k] = corner_value();
      end
      return tri_of(pt[0], pt[1], pt[2], pt[3], pt[4], pt[5], pt[6], pt[7], pt[8]);
   endfunction

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      plan_row_type row;
      row.kind      = ROW_CSR;
      row.csr_idx   = idx;
      row.csr_value = value;
      row.vtx       = '0;
      row.gold      = '0;
      plan_q = {plan_q, row};
   endtask

   task automatic add_gold(input triangle_type t, input logic keep,
                           input logic [MASK_W-1:0] mask);
      plan_row_type row;
      row.kind      = ROW_GOLD;
      row.csr_idx   = '0;
      row.csr_value = '0;
      row.vtx       = t;
      row.gold      = '{keep: keep, facing_mask: mask};
      plan_q = {plan_q, row};
   endtask

   task automatic add_pred(input triangle_type t);
      plan_row_type row;
      row.kind      = ROW_PRED;
      row.csr_idx   = '0;
      row.csr_value = '0;
      row.vtx       = t;
      row.gold      = '0;
      plan_q = {plan_q, row};
   endtask

   // directed table; unit triangle has normal +z, its mirror has -z
   task automatic build_plan();
      triangle_type unit_tri, mirror_tri;
      unit_tri   = tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0);
      mirror_tri = tri_of(0, 0, 0, 0, 1, 0, 1, 0, 0);

      // straight out of reset no eyes are in use: everything culled
      add_gold(tri_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MIN, COORD_MIN, COORD_MIN), 1'b0, 4'b0000);
      add_gold(tri_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MAX, COORD_MAX), 1'b0, 4'b0000);
      add_gold(unit_tri, 1'b0, 4'b0000);
      // a write past the register map changes nothing
      add_csr(REG_UNMAPPED, '1);
      add_gold(unit_tri, 1'b0, 4'b0000);

      // count of seven saturates to four eyes, three along +z and one along -z
      add_csr(REG_EYE0, eye_pack(0, 0, 1));
      add_csr(REG_EYE1, eye_pack(0, 0, COORD_MAX));
      add_csr(REG_EYE2, eye_pack(0, 0, 2));
      add_csr(REG_EYE3, eye_pack(0, 0, COORD_MIN));
      add_csr(REG_EYE_COUNT, '1);
      add_gold(unit_tri, 1'b1, 4'b0111);
      add_gold(mirror_tri, 1'b1, 4'b1000);
      // degenerate triangles are kept
      add_gold(tri_of(5, 5, 5, 5, 5, 5, 5, 5, 5), 1'b1, 4'b0000);
      add_gold(tri_of(0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, 4'b0000);
      // widest spans
      add_pred(tri_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                      COORD_MIN, COORD_MAX, COORD_MIN));
      add_pred(tri_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                      COORD_MAX, COORD_MIN, COORD_MAX));
      add_pred(tri_of(COORD_MIN, COORD_MAX, 0, COORD_MAX, 0, COORD_MIN,
                      0, COORD_MIN, COORD_MAX));

      // single eye along +z culls the unit triangle only
      add_csr(REG_EYE_COUNT, 1);
      add_gold(unit_tri, 1'b0, 4'b0001);
      add_gold(mirror_tri, 1'b1, 4'b0000);

      // eyes just outside and just inside the cone of the unit normal
      add_csr(REG_EYE0, eye_pack(995, 0, 100));
      add_csr(REG_EYE1, eye_pack(994, 0, 100));
      add_csr(REG_EYE_COUNT, 2);
      add_pred(unit_tri);

      // zero eye vector never passes
      add_csr(REG_EYE0, eye_pack(0, 0, 0));
      add_csr(REG_EYE_COUNT, 1);
      add_gold(unit_tri, 1'b1, 4'b0000);

      // four eyes all facing +z, count of five saturates
      add_csr(REG_EYE0, eye_pack(0, 0, 1));
      add_csr(REG_EYE1, eye_pack(0, 0, COORD_MAX));
      add_csr(REG_EYE3, eye_pack(COORD_MIN, COORD_MIN, COORD_MAX));
      add_csr(REG_EYE_COUNT, 5);
      add_gold(unit_tri, 1'b0, 4'b1111);
      add_pred(tri_of(-100, 200, -300, COORD_MAX, COORD_MIN, 1000, COORD_MIN, COORD_MAX, -1000));
      add_csr(REG_EYE_COUNT, 6);
      add_gold(unit_tri, 1'b0, 4'b1111);
      add_pred(tri_of(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 1, -1, 0));
   endtask

   // --------------------------------------------------------------------------
   // bus drivers, all called at a rising edge
   // --------------------------------------------------------------------------
   task automatic drive_vertices(input triangle_type t);
      req_bus.a_x <= t.a_x; req_bus.a_y <= t.a_y; req_bus.a_z <= t.a_z;
      req_bus.b_x <= t.b_x; req_bus.b_y <= t.b_y; req_bus.b_z <= t.b_z;
      req_bus.c_x <= t.c_x; req_bus.c_y <= t.c_y; req_bus.c_z <= t.c_z;
   endtask

   // offer one triangle and return at the edge of its transfer
   task automatic send_triangle(input triangle_type t, input cull_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         // idle with junk on the payload
         req_bus.valid <= 1'b0;
         drive_vertices(random_triangle(0));
         repeat (gap) @(posedge clock);
      end
      staged_q = {staged_q, want};
      req_bus.valid <= 1'b1;
      drive_vertices(t);
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // setup phase then access phase; the select stays up for a following write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << CSR_IDX_LO;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_EYE_COUNT)
         eye_setup.eye_count = value[EYE_COUNT_W-1:0];
      else if (idx >= REG_EYE0 && idx <= REG_EYE3)
         eye_setup.eye_vec[idx - REG_EYE0] = value[EYE_VEC_W-1:0];
   endtask

   task automatic close_csr();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // registers may only change with no triangle in flight
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (staged_q.size() != 0 || awaited_q.size() != 0) @(posedge clock);
   endtask

   // fresh eye setup: mostly a cluster around one axis so culls happen often
   task automatic random_setup(output int axis);
      logic [CSR_DATA_W-1:0] word;
      logic [EYE_W-1:0]      comp [3];
      int                    roll, lead, sgn, i, k;
      bit                    clustered;
      axis      = $urandom_range(0, 2);
      sgn       = $urandom_range(0, 1) ? 1 : -1;
      clustered = $urandom_range(0, 99) < 65;
      for (i = 0; i < EYE_REGS; i++) begin
         roll = $urandom_range(0, 99);
         lead = $urandom_range(1, 32767);
         for (k = 0; k < 3; k++) begin
            if (roll < 5)
               comp[k] = '0;
            else if (clustered)
               comp[k] = (k == axis) ? EYE_W'(sgn * lead) : EYE_W'(spread(lead / 3));
            else if (roll < 30)
               comp[k] = EYE_W'(corner_value());
            else
               comp[k] = EYE_W'($urandom);
         end
         // junk in the unused upper bits
         word = {$urandom, $urandom};
         word[EYE_VEC_W-1:0] = {comp[2], comp[1], comp[0]};
         write_csr(CSR_IDX_W'(REG_EYE0 + i), word);
      end
      roll = $urandom_range(0, 99);
      word = {$urandom, $urandom};
      if (roll < 8)
         word[EYE_COUNT_W-1:0] = '0;
      else if (roll < 20)
         word[EYE_COUNT_W-1:0] = EYE_COUNT_W'($urandom_range(5, 7));
      else
         word[EYE_COUNT_W-1:0] = EYE_COUNT_W'($urandom_range(1, 4));
      write_csr(REG_EYE_COUNT, word);
      if ($urandom_range(0, 2) == 0)
         write_csr(CSR_IDX_W'(REG_UNMAPPED + $urandom_range(0, 2)), {$urandom, $urandom});
   endtask

   // --------------------------------------------------------------------------
   // result side: ready drops for random stretches
   // --------------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 16)) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // --------------------------------------------------------------------------
   // scoreboard: check the result transfer first, then log the triangle
   // transfer of the same edge
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      cull_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_q.size() == 0) begin
               report_mismatch($sformatf("result keep=%0b mask=%b with no triangle waiting",
                                         rsp_bus.keep, rsp_bus.facing_mask));
            end else begin
               want = awaited_q.pop_front();
               if (rsp_bus.keep !== want.keep)
                  report_mismatch($sformatf("keep got %b want %b", rsp_bus.keep, want.keep));
               if (rsp_bus.facing_mask !== want.facing_mask)
                  report_mismatch($sformatf("facing_mask got %b want %b",
                                            rsp_bus.facing_mask, want.facing_mask));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            if (staged_q.size() == 0)
               report_mismatch("triangle transfer with nothing offered");
            else
               awaited_q = {awaited_q, staged_q.pop_front()};
         end
      end
   end

   // --------------------------------------------------------------------------
   // main sequence
   // --------------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type row;
      triangle_type t;
      bit           csr_open;
      int           axis, phase, n;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      drive_vertices('0);
      csr_open = 1'b0;
      build_plan();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, register writes grouped into one bus burst
      foreach (plan_q[i]) begin
         row = plan_q[i];
         if (row.kind == ROW_CSR) begin
            if (!csr_open) wait_idle();
            write_csr(row.csr_idx, row.csr_value);
            csr_open = 1'b1;
         end else begin
            if (csr_open) close_csr();
            csr_open = 1'b0;
            send_triangle(row.vtx, (row.kind == ROW_GOLD) ? row.gold : cull_decision(row.vtx));
         end
      end
      if (csr_open) close_csr();

      // random phases, every third one without gaps on either side
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         idling_on = (phase % 3) != 1;
         random_setup(axis);
         close_csr();
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            t = random_triangle(axis);
            send_triangle(t, cull_decision(t));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_q.size() == 0)
         $display("triangle_view_cull_tb OK");
      else
         $display("triangle_view_cull_tb NOT OK");
      $finish;
   end

   // slowest legal run: ~2020 triangles, each with the longest idle gaps on both
   // sides plus latency; the limit allows over four times that
   initial begin : watchdog
      #12_000_000;
      $display("triangle_view_cull_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire
